// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the radius leader clustering RTL.
// Assertions are compiled in simulation and drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define RLC_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion %m failed");
// Condition that must never be true at a clock edge outside reset.
`define RLC_ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion %m failed");
`else
`define RLC_ASSERT(name, clk, rst_n, prop)
`define RLC_ASSERT_NEVER(name, clk, rst_n, expr)
`endif
`endif

// ===== rtl/rlc_pkg.sv =====
// Package for the radius leader clustering core: sizes, register indexes and
// the command and status structs between controller and datapath. No dependencies.
package rlc_pkg;

    // Sizing of the node store and coordinates.
    localparam int MAX_NODES = 64;
    localparam int COORD_BITS = 16;
    localparam int MAX_DIMS = 3;

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int POS_W = MAX_DIMS * COORD_BITS;
    localparam int LABEL_W = IDX_W + 1;

    // Fixed field widths of the ports.
    localparam int FIELD_COORD_W = 16;
    localparam int RADIUS_W = 17;
    localparam int DIMS_W = 2;
    localparam int NODE_INDEX_W = 6;
    localparam int CLUSTER_W = 6;
    localparam int S_TDATA_W = 3 * FIELD_COORD_W;
    localparam int M_FIELDS_W = NODE_INDEX_W + CLUSTER_W + 2;
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W = M_TDATA_W - M_FIELDS_W;

    // Distance arithmetic widths.
    localparam int MAG_W = COORD_BITS + 1;
    localparam int SQ_W = 2 * MAG_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int R2_W = 2 * RADIUS_W;
    localparam int CMP_W = (SUM_W > R2_W) ? SUM_W : R2_W;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = RADIUS_W;
    localparam logic [CFG_INDEX_W-1:0] REG_CLUSTER_RADIUS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIMS_IN_USE = 1'b1;
    localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load_wr;
        logic             valid_clear;
        logic             head_set;
        logic             pos_rd;
        logic             head_load;
        logic             scan_issue;
        logic             lbl_rd;
        logic             out_load;
        logic             out_last;
        logic             out_ovf;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] cluster;
    } rlc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic addr_valid;
        logic pipe_busy;
        logic out_free;
    } rlc_status_t;

endpackage

// ===== rtl/rlc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rlc_datapath.sv =====
// Datapath of the radius leader clustering core: configuration registers,
// position and label stores, distance pipeline and result register.
// Depends on rlc_pkg, rlc_ram and assert_macros.svh.
`include "assert_macros.svh"

module rlc_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rlc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rlc_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic [rlc_pkg::S_TDATA_W-1:0]     s_tdata,
    input  rlc_pkg::rlc_cmd_t                 cmd,
    output rlc_pkg::rlc_status_t              status,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rlc_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast
);

    import rlc_pkg::*;

    logic [RADIUS_W-1:0]  radius_reg;
    logic [DIMS_W-1:0]    dims_reg;
    logic [R2_W-1:0]      r2_reg;
    logic [DIMS_W-1:0]    eff_dims;

    logic [POS_W-1:0]     pos_wdata;
    logic [POS_W-1:0]     pos_rdata;
    logic [POS_W-1:0]     head_pos_reg;

    logic [LABEL_W-1:0]   lbl_wdata;
    logic [LABEL_W-1:0]   lbl_rdata;
    logic [IDX_W-1:0]     lbl_waddr;
    logic                 lbl_wr;

    logic [MAX_NODES-1:0] valid_reg;
    logic [MAX_NODES-1:0] valid_next;

    logic                 s1_vld_reg;
    logic [IDX_W-1:0]     s1_idx_reg;
    logic                 s2_vld_reg;
    logic [IDX_W-1:0]     s2_idx_reg;
    logic [SQ_W-1:0]      sq_next [MAX_DIMS];
    logic [SQ_W-1:0]      sq_reg  [MAX_DIMS];
    logic [SUM_W-1:0]     dist_sum;
    logic                 join_hit;

    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_last_reg;
    logic                 out_valid_reg;

    // Configuration registers; the squared radius is kept registered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= '0;
            dims_reg   <= DIMS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CLUSTER_RADIUS: radius_reg <= cfg_wr_data[RADIUS_W-1:0];
                REG_DIMS_IN_USE:    dims_reg   <= cfg_wr_data[DIMS_W-1:0];
                default:            radius_reg <= radius_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        r2_reg <= R2_W'(radius_reg) * R2_W'(radius_reg);
    end

    // Zero dimensions counts as one, anything above the maximum as the maximum.
    always_comb begin
        if (dims_reg == '0) begin
            eff_dims = DIMS_W'(1);
        end else if (dims_reg > DIMS_W'(MAX_DIMS)) begin
            eff_dims = DIMS_W'(MAX_DIMS);
        end else begin
            eff_dims = dims_reg;
        end
    end

    // Each stored coordinate is the low COORD_BITS of its input field.
    always_comb begin
        for (int k = 0; k < MAX_DIMS; k++) begin
            pos_wdata[k*COORD_BITS +: COORD_BITS] = s_tdata[k*FIELD_COORD_W +: COORD_BITS];
        end
    end

    rlc_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_NODES)
    ) u_pos_ram (
        .clk     (aclk),
        .wr_en   (cmd.load_wr),
        .wr_addr (cmd.addr),
        .wr_data (pos_wdata),
        .rd_en   (cmd.pos_rd),
        .rd_addr (cmd.addr),
        .rd_data (pos_rdata)
    );

    // The head's coordinates are captured once per cluster.
    always_ff @(posedge aclk) begin
        if (cmd.head_load) begin
            head_pos_reg <= pos_rdata;
        end
    end

    // Stage 1: per-axis difference and square against the current head.
    always_comb begin
        logic signed [COORD_BITS-1:0] head_c;
        logic signed [COORD_BITS-1:0] node_c;
        logic signed [MAG_W-1:0]      diff;
        logic [MAG_W-1:0]             mag;
        for (int k = 0; k < MAX_DIMS; k++) begin
            head_c = signed'(head_pos_reg[k*COORD_BITS +: COORD_BITS]);
            node_c = signed'(pos_rdata[k*COORD_BITS +: COORD_BITS]);
            diff   = MAG_W'(head_c) - MAG_W'(node_c);
            mag    = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
            if (int'(eff_dims) > k) begin
                sq_next[k] = SQ_W'(mag) * SQ_W'(mag);
            end else begin
                sq_next[k] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= cmd.scan_issue && !valid_reg[cmd.addr];
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_idx_reg <= cmd.addr;
        s2_idx_reg <= s1_idx_reg;
        for (int k = 0; k < MAX_DIMS; k++) begin
            sq_reg[k] <= sq_next[k];
        end
    end

    // Stage 2: sum of squares against the squared radius.
    always_comb begin
        dist_sum = '0;
        for (int k = 0; k < MAX_DIMS; k++) begin
            dist_sum = dist_sum + SUM_W'(sq_reg[k]);
        end
    end

    assign join_hit = s2_vld_reg && (CMP_W'(dist_sum) <= CMP_W'(r2_reg));

    // Label writes come from a new head or from a node joining the cluster.
    assign lbl_wr    = cmd.head_set || join_hit;
    assign lbl_waddr = cmd.head_set ? cmd.addr : s2_idx_reg;
    assign lbl_wdata = {cmd.head_set, cmd.cluster};

    rlc_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (MAX_NODES)
    ) u_lbl_ram (
        .clk     (aclk),
        .wr_en   (lbl_wr),
        .wr_addr (lbl_waddr),
        .wr_data (lbl_wdata),
        .rd_en   (cmd.lbl_rd),
        .rd_addr (cmd.addr),
        .rd_data (lbl_rdata)
    );

    // Assigned bits, cleared at the start of each run.
    always_comb begin
        valid_next = valid_reg;
        if (cmd.valid_clear) begin
            valid_next = '0;
        end else begin
            if (cmd.head_set) begin
                valid_next[cmd.addr] = 1'b1;
            end
            if (join_hit) begin
                valid_next[s2_idx_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Result register, loaded only when empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= {{M_PAD_W{1'b0}}, cmd.out_ovf, lbl_rdata[LABEL_W-1],
                             CLUSTER_W'(lbl_rdata[IDX_W-1:0]), NODE_INDEX_W'(cmd.addr)};
            out_last_reg <= cmd.out_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign status.addr_valid = valid_reg[cmd.addr];
    assign status.pipe_busy  = s1_vld_reg || s2_vld_reg;
    assign status.out_free   = !out_valid_reg || m_tready;

    // A pending word is never overwritten.
    `RLC_ASSERT(a_out_no_overwrite, aclk, aresetn, cmd.out_load |-> !out_valid_reg)
    // A joining node is still unassigned when its join is written.
    `RLC_ASSERT(a_join_unassigned, aclk, aresetn, join_hit |-> !valid_reg[s2_idx_reg])
    // A new head is an unassigned node, and never collides with a join write.
    `RLC_ASSERT(a_head_unassigned, aclk, aresetn,
                cmd.head_set |-> (!valid_reg[cmd.addr] && !s2_vld_reg))

endmodule

// ===== rtl/rlc_controller.sv =====
// Controller of the radius leader clustering core: load, head search, scan,
// drain and result phases. Depends on rlc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rlc_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tlast,
    input  rlc_pkg::rlc_status_t status,
    output rlc_pkg::rlc_cmd_t    cmd
);

    import rlc_pkg::*;

    typedef enum logic [6:0] {
        ST_LOAD     = 7'b0000001,
        ST_HEAD_CHK = 7'b0000010,
        ST_HEAD_LAT = 7'b0000100,
        ST_SCAN     = 7'b0001000,
        ST_DRAIN    = 7'b0010000,
        ST_OUT_RD   = 7'b0100000,
        ST_OUT_LOAD = 7'b1000000
    } rlc_state_t;

    rlc_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] cc_reg, cc_next;

    // Next-state and command decode.
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        cc_next     = cc_reg;
        s_tready    = 1'b0;
        cmd         = '0;
        cmd.cluster = cc_reg;
        cmd.addr    = i_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                cmd.addr = cnt_reg[IDX_W-1:0];
                if (s_tvalid) begin
                    if (cnt_reg < CNT_W'(MAX_NODES)) begin
                        cmd.load_wr = 1'b1;
                        cnt_next    = cnt_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        cmd.valid_clear = 1'b1;
                        i_next          = '0;
                        cc_next         = '0;
                        state_next      = ST_HEAD_CHK;
                    end
                end
            end
            ST_HEAD_CHK: begin
                if (i_reg == cnt_reg) begin
                    i_next     = '0;
                    state_next = ST_OUT_RD;
                end else if (status.addr_valid) begin
                    i_next = i_reg + CNT_W'(1);
                end else begin
                    cmd.head_set = 1'b1;
                    cmd.pos_rd   = 1'b1;
                    state_next   = ST_HEAD_LAT;
                end
            end
            ST_HEAD_LAT: begin
                cmd.head_load = 1'b1;
                j_next        = i_reg + CNT_W'(1);
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.addr = j_reg[IDX_W-1:0];
                if (j_reg == cnt_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    cmd.scan_issue = 1'b1;
                    cmd.pos_rd     = 1'b1;
                    j_next         = j_reg + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    cc_next    = cc_reg + IDX_W'(1);
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_HEAD_CHK;
                end
            end
            ST_OUT_RD: begin
                if (status.out_free) begin
                    cmd.lbl_rd = 1'b1;
                    state_next = ST_OUT_LOAD;
                end
            end
            ST_OUT_LOAD: begin
                cmd.out_load = 1'b1;
                cmd.out_ovf  = ovf_reg;
                cmd.out_last = (i_reg + CNT_W'(1) == cnt_reg);
                if (cmd.out_last) begin
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end else begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_OUT_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            cc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            cc_reg    <= cc_next;
        end
    end

    // The node count never passes the store depth.
    `RLC_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= CNT_W'(MAX_NODES))
    // The scan only visits nodes after the current head.
    `RLC_ASSERT(a_scan_after_head, aclk, aresetn, (state_reg == ST_SCAN) |-> (j_reg > i_reg))
    // A run starts from the first node with cluster number zero.
    `RLC_ASSERT(a_run_start, aclk, aresetn,
                (state_reg == ST_LOAD && s_tvalid && s_tlast) |=> (i_reg == '0 && cc_reg == '0))
    // The head index stays within the loaded set during a run.
    `RLC_ASSERT_NEVER(a_head_range, aclk, aresetn,
                      (state_reg == ST_HEAD_LAT || state_reg == ST_SCAN) && (i_reg >= cnt_reg))

endmodule

// ===== rtl/radius_leader_clustering_core.sv =====
// Operation: load words go into the position RAM as they arrive. In a run, each head
// scans the later nodes one per cycle through the position RAM port, after a head
// fetch and before a pipeline drain; then each result is read out and sent.
// Throughput: one clustering run at a time; inputs are accepted only in the load phase.
// Reset: aresetn is synchronous, active low; it clears counters, assigned bits and
// configuration (radius 0, two dimensions). The position and label RAMs are not cleared.
module radius_leader_clustering_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [rlc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rlc_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: pos_x [15:0], pos_y [31:16], pos_z [47:32]
    input  logic [rlc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: node_index [5:0], cluster_number [11:6], is_head [12],
    // overflowed [13], zero [15:14]
    output logic [rlc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);

    import rlc_pkg::*;

    rlc_cmd_t    cmd;
    rlc_status_t status;

    // Sequencer.
    rlc_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    // Stores, distance pipeline and result register.
    rlc_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule
